### rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Check that a condition on one edge brings a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/fpba_pkg.sv
`timescale 1ns / 1ps
package fpba_pkg;
   localparam int LEN_W   = 16;
   localparam int OWNER_W = 8;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_NEXT  = 2'd1;
   localparam logic [1:0] POL_BEST  = 2'd2;
   localparam logic [1:0] POL_WORST = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] ST_FREE_FAIL  = 2'd2;
   localparam logic [1:0] ST_TABLE_FULL = 2'd3;

   localparam logic CSR_POOL_BASE = 1'b0;
   localparam logic CSR_POOL_SIZE = 1'b1;

   localparam logic [LEN_W-1:0] POOL_SIZE_RESET = 16'd4096;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_INIT   = 6'b000010,
      S_SCAN_U = 6'b000100,
      S_SCAN_F = 6'b001000,
      S_COMMIT = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;
endpackage

### rtl/core/fpba_ram.sv
`timescale 1ns / 1ps
module fpba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/core/fpba_fit_cmp.sv
`timescale 1ns / 1ps
module fpba_fit_cmp
   import fpba_pkg::*;
#(
   parameter int AW = 16
) (
   input  logic [1:0]       policy,
   input  logic [AW-1:0]    mark,
   input  logic [AW-1:0]    cand_start,
   input  logic [LEN_W-1:0] cand_len,
   input  logic             best_found,
   input  logic [AW-1:0]    best_start,
   input  logic [LEN_W-1:0] best_len,
   input  logic             best_region,
   output logic             take,
   output logic             cand_region
);
   logic lower;

   // region 0 lies at or after the next-fit mark, region 1 before it
   assign cand_region = (cand_start < mark);
   assign lower       = (cand_start < best_start);

   always_comb begin
      if (!best_found) begin
         take = 1'b1;
      end else begin
         case (policy)
            POL_FIRST: take = lower;
            POL_NEXT:  take = (!cand_region && best_region) ||
                              ((cand_region == best_region) && lower);
            POL_BEST:  take = (cand_len < best_len) || ((cand_len == best_len) && lower);
            default:   take = (cand_len > best_len) || ((cand_len == best_len) && lower);
         endcase
      end
   end
endmodule

### rtl/core/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// Block allocator for one contiguous pool. An allocate transaction picks a free
// block by first, next, best or worst fit (ties to the lower address), carves
// the request from its low end and records it in the used table; a free
// transaction releases the owner's lowest-addressed block and merges it with
// touching free blocks. Both tables live in single-port-write, registered-read
// RAMs with valid bits in flops. One transaction is handled at a time: one pass
// over the used table, one pass over the free table (each one entry per cycle
// through the RAM read port), a write-back step and a result step. Rejected
// requests (zero or oversize allocate, free of owner 0) skip both passes and go
// straight to the result step. After reset or any write to pool_base or
// pool_size the block rewrites free entry 0 before it takes the next
// transaction.
module fit_policy_block_allocator
   import fpba_pkg::*;
#(
   parameter int FREE_ENTRIES = 16,
   parameter int USED_ENTRIES = 16,
   parameter int ADDR_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [1:0]  req_policy,
   input  logic [7:0]  req_owner,
   input  logic [15:0] req_request_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_block_address,
   output logic [15:0] rsp_block_size,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
`include "assert_macros.svh"

   localparam int AW    = ADDR_BITS;
   localparam int FI_W  = $clog2(FREE_ENTRIES);
   localparam int UI_W  = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
   localparam int MAXN  = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
   localparam int CNT_W = $clog2(MAXN + 1);
   localparam int FW    = AW + LEN_W;
   localparam int UW    = AW + LEN_W + OWNER_W;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [15:0]       pool_base_ff, pool_base_in;
   logic [LEN_W-1:0]  pool_size_ff, pool_size_in;
   logic [AW-1:0]     mark_ff, mark_in;
   logic [FREE_ENTRIES-1:0] fvalid_ff, fvalid_in;
   logic [USED_ENTRIES-1:0] uvalid_ff, uvalid_in;

   // latched request
   logic              cmd_ff, cmd_in;
   logic [1:0]        pol_ff, pol_in;
   logic [7:0]        own_ff, own_in;
   logic [LEN_W-1:0]  size_ff, size_in;

   // scan results
   logic              slot_ok_ff, slot_ok_in;
   logic [UI_W-1:0]   slot_ff, slot_in;
   logic              u_ok_ff, u_ok_in;
   logic [UI_W-1:0]   u_idx_ff, u_idx_in;
   logic [AW-1:0]     u_s_ff, u_s_in;
   logic [LEN_W-1:0]  u_l_ff, u_l_in;
   logic              b_ok_ff, b_ok_in;
   logic [FI_W-1:0]   b_idx_ff, b_idx_in;
   logic [AW-1:0]     b_s_ff, b_s_in;
   logic [LEN_W-1:0]  b_l_ff, b_l_in;
   logic              b_reg_ff, b_reg_in;
   logic              p_ok_ff, p_ok_in;
   logic [FI_W-1:0]   p_idx_ff, p_idx_in;
   logic [AW-1:0]     p_s_ff, p_s_in;
   logic [LEN_W-1:0]  p_l_ff, p_l_in;
   logic              n_ok_ff, n_ok_in;
   logic [FI_W-1:0]   n_idx_ff, n_idx_in;
   logic [LEN_W-1:0]  n_l_ff, n_l_in;
   logic              e_ok_ff, e_ok_in;
   logic [FI_W-1:0]   e_idx_ff, e_idx_in;

   // pending result and output register
   logic [1:0]        res_st_ff, res_st_in;
   logic [AW-1:0]     res_a_ff, res_a_in;
   logic [LEN_W-1:0]  res_l_ff, res_l_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_st_ff, rsp_st_in;
   logic [15:0]       rsp_a_ff, rsp_a_in;
   logic [LEN_W-1:0]  rsp_l_ff, rsp_l_in;

   // RAM ports
   logic              f_we, u_we;
   logic [FI_W-1:0]   f_wa;
   logic [UI_W-1:0]   u_wa;
   logic [FW-1:0]     f_wd, f_rd;
   logic [UW-1:0]     u_wd, u_rd;

   logic [CNT_W-1:0]  k;
   logic [FI_W-1:0]   kf;
   logic [UI_W-1:0]   ku;
   logic [AW-1:0]     fr_s, ur_s, base_a, size_a, ul_a, fl_a, u_end;
   logic [LEN_W-1:0]  fr_l, ur_l;
   logic [OWNER_W-1:0] ur_o;
   logic [AW+15:0]    base_w, size_w, ul_w, fl_w, wb_w, res_w;
   logic [15:0]       wr_base;
   logic              take, cand_reg, rsp_free;

   assign base_w = {{AW{1'b0}}, pool_base_ff};
   assign size_w = {{AW{1'b0}}, size_ff};
   assign ul_w   = {{AW{1'b0}}, u_l_ff};
   assign fl_w   = {{AW{1'b0}}, fr_l};
   assign base_a = base_w[AW-1:0];
   assign size_a = size_w[AW-1:0];
   assign ul_a   = ul_w[AW-1:0];
   assign fl_a   = fl_w[AW-1:0];
   assign u_end  = u_s_ff + ul_a;
   assign wb_w   = {{AW{1'b0}}, csr_wdata};
   assign wr_base = csr_wdata;

   assign fr_s = f_rd[FW-1:LEN_W];
   assign fr_l = f_rd[LEN_W-1:0];
   assign ur_s = u_rd[UW-1:LEN_W+OWNER_W];
   assign ur_l = u_rd[LEN_W+OWNER_W-1:OWNER_W];
   assign ur_o = u_rd[OWNER_W-1:0];

   // entry being checked is the one addressed in the previous cycle (registered RAM read)
   assign k  = cnt_ff - CNT_W'(1);
   assign kf = k[FI_W-1:0];
   assign ku = k[UI_W-1:0];

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   fpba_ram #(.WIDTH(FW), .DEPTH(FREE_ENTRIES), .AW(FI_W)) u_free_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_wa),
      .wr_data (f_wd),
      .rd_addr (cnt_ff[FI_W-1:0]),
      .rd_data (f_rd)
   );

   fpba_ram #(.WIDTH(UW), .DEPTH(USED_ENTRIES), .AW(UI_W)) u_used_ram (
      .clock   (clock),
      .wr_en   (u_we),
      .wr_addr (u_wa),
      .wr_data (u_wd),
      .rd_addr (cnt_ff[UI_W-1:0]),
      .rd_data (u_rd)
   );

   fpba_fit_cmp #(.AW(AW)) u_fit_cmp (
      .policy      (pol_ff),
      .mark        (mark_ff),
      .cand_start  (fr_s),
      .cand_len    (fr_l),
      .best_found  (b_ok_ff),
      .best_start  (b_s_ff),
      .best_len    (b_l_ff),
      .best_region (b_reg_ff),
      .take        (take),
      .cand_region (cand_reg)
   );

   always_comb begin
      state_in = state_ff;   cnt_in = cnt_ff;
      pool_base_in = pool_base_ff; pool_size_in = pool_size_ff; mark_in = mark_ff;
      fvalid_in = fvalid_ff; uvalid_in = uvalid_ff;
      cmd_in = cmd_ff; pol_in = pol_ff; own_in = own_ff; size_in = size_ff;
      slot_ok_in = slot_ok_ff; slot_in = slot_ff;
      u_ok_in = u_ok_ff; u_idx_in = u_idx_ff; u_s_in = u_s_ff; u_l_in = u_l_ff;
      b_ok_in = b_ok_ff; b_idx_in = b_idx_ff; b_s_in = b_s_ff; b_l_in = b_l_ff;
      b_reg_in = b_reg_ff;
      p_ok_in = p_ok_ff; p_idx_in = p_idx_ff; p_s_in = p_s_ff; p_l_in = p_l_ff;
      n_ok_in = n_ok_ff; n_idx_in = n_idx_ff; n_l_in = n_l_ff;
      e_ok_in = e_ok_ff; e_idx_in = e_idx_ff;
      res_st_in = res_st_ff; res_a_in = res_a_ff; res_l_in = res_l_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_st_in = rsp_st_ff; rsp_a_in = rsp_a_ff; rsp_l_in = rsp_l_ff;
      f_we = 1'b0; f_wa = '0; f_wd = '0;
      u_we = 1'b0; u_wa = slot_ff; u_wd = {b_s_ff, size_ff, own_ff};
      req_stall = 1'b1;

      unique case (state_ff)
         S_INIT: begin
            // rewrite the single free block that covers the pool
            f_we = 1'b1; f_wa = '0; f_wd = {base_a, pool_size_ff};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in = req_command; pol_in = req_policy;
               own_in = req_owner;   size_in = req_request_size;
               cnt_in = '0;
               slot_ok_in = 1'b0; u_ok_in = 1'b0; b_ok_in = 1'b0;
               p_ok_in = 1'b0; n_ok_in = 1'b0; e_ok_in = 1'b0;
               res_a_in = '0; res_l_in = '0;
               if (req_command == CMD_ALLOC &&
                   (req_request_size == '0 || req_request_size > pool_size_ff)) begin
                  res_st_in = ST_ALLOC_FAIL; state_in = S_RESP;
               end else if (req_command == CMD_FREE && req_owner == '0) begin
                  res_st_in = ST_FREE_FAIL;  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN_U;
               end
            end
         end
         S_SCAN_U: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0) begin
               if (cmd_ff == CMD_ALLOC) begin
                  if (!slot_ok_ff && !uvalid_ff[ku]) begin
                     slot_ok_in = 1'b1; slot_in = ku;
                  end
               end else if (uvalid_ff[ku] && ur_o == own_ff &&
                            (!u_ok_ff || ur_s < u_s_ff)) begin
                  u_ok_in = 1'b1; u_idx_in = ku; u_s_in = ur_s; u_l_in = ur_l;
               end
            end
            if (cnt_ff == CNT_W'(USED_ENTRIES)) begin
               cnt_in = '0;
               // fold in the last entry's outcome before branching
               if (cmd_ff == CMD_ALLOC && !slot_ok_in) begin
                  res_st_in = ST_TABLE_FULL; state_in = S_RESP;
               end else if (cmd_ff == CMD_FREE && !u_ok_in) begin
                  res_st_in = ST_FREE_FAIL;  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN_F;
               end
            end
         end
         S_SCAN_F: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0) begin
               if (cmd_ff == CMD_ALLOC) begin
                  if (fvalid_ff[kf] && fr_l >= size_ff && take) begin
                     b_ok_in = 1'b1; b_idx_in = kf; b_s_in = fr_s; b_l_in = fr_l;
                     b_reg_in = cand_reg;
                  end
               end else if (fvalid_ff[kf]) begin
                  if (!p_ok_ff && (fr_s + fl_a) == u_s_ff) begin
                     p_ok_in = 1'b1; p_idx_in = kf; p_s_in = fr_s; p_l_in = fr_l;
                  end else if (!n_ok_ff && fr_s == u_end) begin
                     n_ok_in = 1'b1; n_idx_in = kf; n_l_in = fr_l;
                  end
               end else if (!e_ok_ff) begin
                  e_ok_in = 1'b1; e_idx_in = kf;
               end
            end
            if (cnt_ff == CNT_W'(FREE_ENTRIES)) begin
               cnt_in = '0; state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            state_in = S_RESP;
            res_st_in = ST_OK; res_a_in = '0; res_l_in = '0;
            if (cmd_ff == CMD_ALLOC) begin
               if (!b_ok_ff) begin
                  res_st_in = ST_ALLOC_FAIL;
               end else begin
                  u_we = 1'b1;
                  uvalid_in[slot_ff] = 1'b1;
                  mark_in = b_s_ff;
                  res_a_in = b_s_ff; res_l_in = size_ff;
                  if (b_l_ff == size_ff) begin
                     fvalid_in[b_idx_ff] = 1'b0;
                  end else begin
                     f_we = 1'b1; f_wa = b_idx_ff;
                     f_wd = {b_s_ff + size_a, b_l_ff - size_ff};
                  end
               end
            end else begin
               res_a_in = u_s_ff; res_l_in = u_l_ff;
               if (p_ok_ff && n_ok_ff) begin
                  f_we = 1'b1; f_wa = p_idx_ff; f_wd = {p_s_ff, p_l_ff + u_l_ff + n_l_ff};
                  fvalid_in[n_idx_ff] = 1'b0;
               end else if (p_ok_ff) begin
                  f_we = 1'b1; f_wa = p_idx_ff; f_wd = {p_s_ff, p_l_ff + u_l_ff};
               end else if (n_ok_ff) begin
                  f_we = 1'b1; f_wa = n_idx_ff; f_wd = {u_s_ff, n_l_ff + u_l_ff};
               end else if (e_ok_ff) begin
                  f_we = 1'b1; f_wa = e_idx_ff; f_wd = {u_s_ff, u_l_ff};
                  fvalid_in[e_idx_ff] = 1'b1;
               end
               if (p_ok_ff || n_ok_ff || e_ok_ff) begin
                  uvalid_in[u_idx_ff] = 1'b0;
               end else begin
                  // no room for the released block: keep the used entry
                  res_st_in = ST_TABLE_FULL; res_a_in = '0; res_l_in = '0;
               end
            end
         end
         S_RESP: begin
            // hold until the output register drains
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_st_in = res_st_ff; rsp_a_in = res_w[15:0]; rsp_l_in = res_l_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // pool register write: clear both tables, restart from one free block (none if the size is zero)
      if (csr_write) begin
         if (csr_index == CSR_POOL_BASE) begin
            pool_base_in = wr_base;
            mark_in = wb_w[AW-1:0];
            fvalid_in = FREE_ENTRIES'(pool_size_ff != '0);
         end else begin
            pool_size_in = csr_wdata;
            mark_in = base_a;
            fvalid_in = FREE_ENTRIES'(csr_wdata != '0);
         end
         uvalid_in = '0;
         state_in = S_INIT;
      end
   end

   assign res_w = {16'b0, res_a_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         pool_base_ff <= '0;
         pool_size_ff <= POOL_SIZE_RESET;
         mark_ff      <= '0;
         fvalid_ff    <= FREE_ENTRIES'(1);
         uvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pool_base_ff <= pool_base_in;
         pool_size_ff <= pool_size_in;
         mark_ff      <= mark_in;
         fvalid_ff    <= fvalid_in;
         uvalid_ff    <= uvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; pol_ff <= pol_in; own_ff <= own_in; size_ff <= size_in;
      slot_ok_ff <= slot_ok_in; slot_ff <= slot_in;
      u_ok_ff <= u_ok_in; u_idx_ff <= u_idx_in; u_s_ff <= u_s_in; u_l_ff <= u_l_in;
      b_ok_ff <= b_ok_in; b_idx_ff <= b_idx_in; b_s_ff <= b_s_in; b_l_ff <= b_l_in;
      b_reg_ff <= b_reg_in;
      p_ok_ff <= p_ok_in; p_idx_ff <= p_idx_in; p_s_ff <= p_s_in; p_l_ff <= p_l_in;
      n_ok_ff <= n_ok_in; n_idx_ff <= n_idx_in; n_l_ff <= n_l_in;
      e_ok_ff <= e_ok_in; e_idx_ff <= e_idx_in;
      res_st_ff <= res_st_in; res_a_ff <= res_a_in; res_l_ff <= res_l_in;
      rsp_st_ff <= rsp_st_in; rsp_a_ff <= rsp_a_in; rsp_l_ff <= rsp_l_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_st_ff;
   assign rsp_block_address = rsp_a_ff;
   assign rsp_block_size    = rsp_l_ff;

   // a failed transaction reports no block
   `ASSERT_ALWAYS(a_fail_zero, clock, reset,
      !rsp_valid_ff || rsp_st_ff == ST_OK || (rsp_a_ff == '0 && rsp_l_ff == '0))
   // write-back hands over to the result stage unless a pool register write intervenes
   `ASSERT_NEXT(a_commit_resp, clock, reset, state_ff == S_COMMIT && !csr_write,
      state_ff == S_RESP)
   // scan index never runs past the larger table
   `ASSERT_ALWAYS(a_cnt_range, clock, reset, cnt_ff <= CNT_W'(MAXN))
endmodule

### bench/tb_fit_policy_block_allocator.sv
`timescale 1ns / 1ps
module tb_fit_policy_block_allocator
   import fpba_pkg::*;
();

   localparam int NFREE      = 16;
   localparam int NUSED      = 16;
   localparam int QUIET_WAIT = 60;    // a bit over one full transaction
   localparam int STUCK_MAX  = 5000;  // cycles with no transaction at all

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] addr;
      logic [15:0] size;
   } grant_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [1:0]  req_policy;
   logic [7:0]  req_owner;
   logic [15:0] req_request_size;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_block_address;
   logic [15:0] rsp_block_size;
   logic        csr_write;
   logic        csr_index;
   logic [15:0] csr_wdata;

   fit_policy_block_allocator u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_policy        (req_policy),
      .req_owner         (req_owner),
      .req_request_size  (req_request_size),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_block_size    (rsp_block_size),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow of the allocator state.
   logic [15:0] pool_base, pool_size, rover;
   logic [15:0] free_at [NFREE];
   logic [15:0] free_len[NFREE];
   logic        free_ok [NFREE];
   logic [15:0] used_at [NUSED];
   logic [15:0] used_len[NUSED];
   logic [7:0]  used_who[NUSED];
   logic        used_ok [NUSED];

   grant_type pending_grants[$];
   int     error_count;
   int     send_idle_pct;
   int     recv_stall_pct;
   int     stuck_cycles;

   // Rebuild both tables as one free block spanning the pool (none for an empty pool).
   function automatic void clear_pool();
      for (int i = 0; i < NFREE; i++) begin
         free_ok[i]  = 1'b0;
         free_at[i]  = '0;
         free_len[i] = '0;
      end
      for (int i = 0; i < NUSED; i++)
         used_ok[i] = 1'b0;
      if (pool_size != 0) begin
         free_ok[0]  = 1'b1;
         free_at[0]  = pool_base;
         free_len[0] = pool_size;
      end
      rover = pool_base;
   endfunction

   function automatic grant_type alloc_outcome(logic [1:0] pol, logic [7:0] who,
                                               logic [15:0] sz);
      grant_type g;
      int slot, pick;
      logic pick_wrapped, wrapped, take;
      g = '{ST_OK, 16'd0, 16'd0};
      slot = -1;
      pick = -1;
      pick_wrapped = 1'b0;
      if (sz == 0 || sz > pool_size) begin
         g.status = ST_ALLOC_FAIL;
         return g;
      end
      for (int i = 0; i < NUSED; i++)
         if (!used_ok[i] && slot < 0) slot = i;
      if (slot < 0) begin
         g.status = ST_TABLE_FULL;
         return g;
      end
      for (int i = 0; i < NFREE; i++) begin
         if (free_ok[i] && free_len[i] >= sz) begin
            // blocks below the next-fit mark rank after those above it
            wrapped = (free_at[i] < rover);
            if (pick < 0) take = 1'b1;
            else case (pol)
               POL_FIRST: take = free_at[i] < free_at[pick];
               POL_NEXT:  take = (!wrapped && pick_wrapped) ||
                                 (wrapped == pick_wrapped && free_at[i] < free_at[pick]);
               POL_BEST:  take = free_len[i] < free_len[pick] ||
                                 (free_len[i] == free_len[pick] && free_at[i] < free_at[pick]);
               default:   take = free_len[i] > free_len[pick] ||
                                 (free_len[i] == free_len[pick] && free_at[i] < free_at[pick]);
            endcase
            if (take) begin
               pick = i;
               pick_wrapped = wrapped;
            end
         end
      end
      if (pick < 0) begin
         g.status = ST_ALLOC_FAIL;
         return g;
      end
      g.addr = free_at[pick];
      g.size = sz;
      used_ok[slot]  = 1'b1;
      used_at[slot]  = g.addr;
      used_len[slot] = sz;
      used_who[slot] = who;
      rover = g.addr;
      if (free_len[pick] == sz) begin
         free_ok[pick] = 1'b0;
      end else begin
         free_at[pick]  = g.addr + sz;
         free_len[pick] = free_len[pick] - sz;
      end
      return g;
   endfunction

   function automatic grant_type release_outcome(logic [7:0] who);
      grant_type g;
      int u, below, above, hole;
      logic [15:0] tail;
      g = '{ST_FREE_FAIL, 16'd0, 16'd0};
      u = -1;
      below = -1;
      above = -1;
      hole = -1;
      if (who == 0) return g;
      for (int i = 0; i < NUSED; i++)
         if (used_ok[i] && used_who[i] == who && (u < 0 || used_at[i] < used_at[u]))
            u = i;
      if (u < 0) return g;
      tail = used_at[u] + used_len[u];
      for (int i = 0; i < NFREE; i++) begin
         if (free_ok[i]) begin
            if (below < 0 && 16'(free_at[i] + free_len[i]) == used_at[u]) below = i;
            else if (above < 0 && free_at[i] == tail) above = i;
         end
      end
      if (below >= 0 && above >= 0) begin
         free_len[below] = free_len[below] + used_len[u] + free_len[above];
         free_ok[above] = 1'b0;
      end else if (below >= 0) begin
         free_len[below] = free_len[below] + used_len[u];
      end else if (above >= 0) begin
         free_at[above]  = used_at[u];
         free_len[above] = free_len[above] + used_len[u];
      end else begin
         for (int i = 0; i < NFREE; i++)
            if (!free_ok[i] && hole < 0) hole = i;
         if (hole < 0) begin
            g.status = ST_TABLE_FULL;
            return g;
         end
         free_ok[hole]  = 1'b1;
         free_at[hole]  = used_at[u];
         free_len[hole] = used_len[u];
      end
      used_ok[u] = 1'b0;
      g = '{ST_OK, used_at[u], used_len[u]};
      return g;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Drive one transaction and hold it until accepted; predict on acceptance.
   task automatic send_req(logic cmd, logic [1:0] pol, logic [7:0] who, logic [15:0] sz);
      grant_type g;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_policy       <= pol;
      req_owner        <= who;
      req_request_size <= sz;
      do @(posedge clock); while (req_stall);
      if (cmd == CMD_ALLOC) g = alloc_outcome(pol, who, sz);
      else g = release_outcome(who);
      pending_grants = {pending_grants, g};
   endtask

   // Drop valid and wait until every predicted response has come back.
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_POOL_BASE) pool_base = val;
      else pool_size = val;
      clear_pool();
   endtask

   task automatic program_pool(logic [15:0] base, logic [15:0] size);
      write_csr(CSR_POOL_BASE, base);
      write_csr(CSR_POOL_SIZE, size);
   endtask

   task automatic test_rejects();
      send_req(CMD_ALLOC, POL_WORST, 8'hFF, 16'd0);      // zero size
      send_req(CMD_ALLOC, POL_FIRST, 8'd1, 16'hFFFF);    // above pool size
      send_req(CMD_FREE, POL_NEXT, 8'd0, 16'hFFFF);      // owner zero
      send_req(CMD_FREE, POL_BEST, 8'd77, 16'd5);        // owner holds nothing
      wait_quiet();
      program_pool(16'd0, 16'd0);                        // empty pool
      send_req(CMD_ALLOC, POL_FIRST, 8'd1, 16'd1);
      wait_quiet();
   endtask

   task automatic test_policies();
      program_pool(16'd0, 16'd100);
      send_req(CMD_ALLOC, POL_FIRST, 8'd1, 16'd10);
      send_req(CMD_ALLOC, POL_FIRST, 8'd2, 16'd20);
      send_req(CMD_ALLOC, POL_FIRST, 8'd3, 16'd5);
      send_req(CMD_ALLOC, POL_FIRST, 8'd4, 16'd30);
      send_req(CMD_FREE, POL_FIRST, 8'd1, 16'd0);
      send_req(CMD_FREE, POL_FIRST, 8'd3, 16'd0);
      send_req(CMD_ALLOC, POL_BEST, 8'd5, 16'd4);        // smallest hole
      send_req(CMD_ALLOC, POL_WORST, 8'd6, 16'd4);       // tail region
      send_req(CMD_ALLOC, POL_NEXT, 8'd7, 16'd40);       // no hole is large enough
      wait_quiet();
   endtask

   task automatic test_used_full();
      program_pool(16'hFFF8, 16'd64);                    // pool wraps past the top
      for (int i = 1; i <= NUSED + 1; i++)
         send_req(CMD_ALLOC, 2'($urandom_range(3)), 8'(i), 16'd1);
      wait_quiet();
   endtask

   // Interleave allocations and releases to split the pool into many holes.
   task automatic test_fragment();
      program_pool(16'd0, 16'd64);
      for (int i = 1; i <= NUSED; i++) send_req(CMD_ALLOC, POL_FIRST, 8'(i), 16'd1);
      for (int i = 2; i < NUSED; i += 2) send_req(CMD_FREE, POL_FIRST, 8'(i), 16'd0);
      for (int i = 0; i < 8; i++) begin
         send_req(CMD_ALLOC, POL_WORST, 8'd100, 16'd1);
         send_req(CMD_ALLOC, POL_WORST, 8'd200, 16'd1);
         send_req(CMD_FREE, POL_FIRST, 8'd100, 16'd0);
      end
      wait_quiet();
   endtask

   task automatic test_random(int n, logic [15:0] base, logic [15:0] size,
                              int idle_pct, int stall_pct);
      logic        cmd;
      logic [7:0]  who;
      logic [15:0] sz;
      int          pick;
      program_pool(base, size);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int k = 0; k < n; k++) begin
         cmd = ($urandom_range(99) < 60) ? CMD_ALLOC : CMD_FREE;
         who = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 6));
         pick = $urandom_range(99);
         if (pick < 4) sz = 16'd0;
         else if (pick < 10) sz = 16'($urandom_range(65535));
         else if (pick < 14) sz = size;
         else sz = 16'($urandom_range(1, (size > 16) ? size / 8 : 1));
         send_req(cmd, 2'($urandom_range(3)), who, sz);
      end
      wait_quiet();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   always @(negedge clock)
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_status, -1);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_block_address !== want.addr)
               report_mismatch("block_address", rsp_block_address, want.addr);
            if (rsp_block_size !== want.size)
               report_mismatch("block_size", rsp_block_size, want.size);
         end
      end
   end

   // Abort when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_MAX) begin
         $display("fit_policy_block_allocator test failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_command      <= CMD_ALLOC;
      req_policy       <= POL_FIRST;
      req_owner        <= '0;
      req_request_size <= '0;
      rsp_stall        <= 1'b0;
      csr_write        <= 1'b0;
      csr_index        <= CSR_POOL_BASE;
      csr_wdata        <= '0;
      error_count    = 0;
      stuck_cycles   = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      pool_base      = 16'd0;
      pool_size      = POOL_SIZE_RESET;
      clear_pool();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_rejects();
      test_policies();
      test_used_full();
      test_fragment();
      // random phases: extremes first, then idle/stall patterns, then the reset-size pool
      test_random(100, 16'hFFFF, 16'hFFFF, 0, 0);
      test_random(150, 16'd65500, 16'd200, 77, 0);
      test_random(100, 16'd0, 16'd1, 0, 77);
      test_random(150, 16'd1234, 16'd300, 8, 8);
      test_random(50, 16'd0, POOL_SIZE_RESET, 0, 0);

      if (error_count == 0) $display("fit_policy_block_allocator test passed");
      else $display("fit_policy_block_allocator test failed");
      $finish;
   end
endmodule
